// ===== rtl/kst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed slot table: operation and status
// codes, field widths and the layout of one stored slot.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int KEY_W          = 64;
    localparam int WORD_W         = 64;
    localparam int OP_W           = 3;
    localparam int STATUS_W       = 2;
    localparam int SLOT_OUT_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER     = 3'd0,
        OP_UNREGISTER   = 3'd1,
        OP_WRITE_FIRST  = 3'd2,
        OP_WRITE_SECOND = 3'd3,
        OP_READ_FIRST   = 3'd4,
        OP_READ_SECOND  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_KEY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } t_row;

endpackage
`default_nettype wire

// ===== rtl/keyed_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_slot_table
// Fully associative table of 64-bit keys, each slot holding two payload words.
//
// Usage: a command beat on the slave side carries the operation in tuser and
// the key and payload word in tdata. Every command answers with exactly one
// beat on the master side (status, slot index, read word).
// A command with a nonzero key and a used operation walks the slot memory one
// slot a cycle through one shared key comparator, ending the walk at a hit; a
// zero key or an unused operation skips the walk. The result register loads
// in the action state once no earlier result beat is still held.
// One command is in work at a time; s_tready is high again in the cycle after
// the result is loaded, so a new command is never accepted before then.
// A stalled receiver holds the result beat; the next command is accepted and
// scanned meanwhile but waits before its update until the held beat is taken.
// Reset clears all slot valid bits at once, so every slot reads as empty and
// no clearing pass is needed; register zeroes both payload words of a slot.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
    parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // entity_key[63:0], payload_word[127:64]
    input  wire logic [2:0]   i_s_tuser,   // operation[2:0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [71:0]       o_m_tdata    // status[1:0], slot_index[5:2],
                                           // read_word[69:6], zero[71:70]
);
    import kst_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [WORD_W-1:0]     r_word, n_word;
    logic                  r_trivial, n_trivial;
    t_status               r_status, n_status;
    logic [IW-1:0]         r_addr, n_addr;
    logic                  r_issue, n_issue;
    logic [IW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_hit_idx, n_hit_idx;
    t_row                  r_hit_row, n_hit_row;
    logic                  r_empty_found, n_empty_found;
    logic [IW-1:0]         r_empty_idx, n_empty_idx;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot, n_out_slot;
    logic [WORD_W-1:0]     r_out_word, n_out_word;

    t_row                  r_mem [SLOT_COUNT];
    t_row                  r_rd_row;

    logic                  w_mem_we;
    logic [IW-1:0]         w_mem_waddr;
    t_row                  w_mem_wdata;
    logic                  w_load;
    logic                  w_cmp_hit;
    logic [IW-1:0]         w_act_idx;
    t_status               w_res_status;
    logic [WORD_W-1:0]     w_res_word;
    logic [IW+SLOT_OUT_W-1:0] w_slot_ext;

    assign w_cmp_hit  = r_valid[r_cmp_idx] && (r_rd_row.key == r_key);
    assign w_slot_ext = {{SLOT_OUT_W{1'b0}}, w_act_idx};

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_key         = r_key;
        n_word        = r_word;
        n_trivial     = r_trivial;
        n_status      = r_status;
        n_addr        = r_addr;
        n_issue       = r_issue;
        n_cmp_idx     = r_cmp_idx;
        n_cmp_vld     = r_cmp_vld;
        n_found       = r_found;
        n_hit_idx     = r_hit_idx;
        n_hit_row     = r_hit_row;
        n_empty_found = r_empty_found;
        n_empty_idx   = r_empty_idx;
        n_valid       = r_valid;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_word    = r_out_word;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_hit_idx;
        w_mem_wdata   = r_hit_row;
        w_load        = 1'b0;
        w_act_idx     = r_hit_idx;
        w_res_status  = ST_OK;
        w_res_word    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op          = t_op'(i_s_tuser);
                    n_key         = i_s_tdata[63:0];
                    n_word        = i_s_tdata[127:64];
                    n_found       = 1'b0;
                    n_empty_found = 1'b0;
                    n_addr        = '0;
                    n_issue       = 1'b1;
                    n_cmp_vld     = 1'b0;
                    n_status      = ST_OK;
                    if (i_s_tuser > OP_READ_SECOND) begin
                        n_trivial = 1'b1;
                        n_state   = S_ACT;
                    end else if (i_s_tdata[63:0] == '0) begin
                        n_trivial = 1'b1;
                        n_status  = ST_ZERO_KEY;
                        n_state   = S_ACT;
                    end else begin
                        n_trivial = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = r_issue;
                if (r_issue) begin
                    n_cmp_idx = r_addr;
                    if (r_addr == LAST_SLOT) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (w_cmp_hit) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_row = r_rd_row;
                        n_issue   = 1'b0;
                        n_state   = S_ACT;
                    end else begin
                        if (!r_valid[r_cmp_idx] && !r_empty_found) begin
                            n_empty_found = 1'b1;
                            n_empty_idx   = r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST_SLOT) begin
                            n_state = S_ACT;
                        end
                    end
                end
            end
            S_ACT: begin
                w_load = !r_out_valid || i_m_tready;
                if (r_trivial) begin
                    w_res_status = r_status;
                end else begin
                    case (r_op)
                        OP_REGISTER: begin
                            if (!r_found) begin
                                if (r_empty_found) begin
                                    w_act_idx   = r_empty_idx;
                                    w_mem_waddr = r_empty_idx;
                                    w_mem_wdata = '{key: r_key, first: '0, second: '0};
                                    w_mem_we    = w_load;
                                    if (w_load) begin
                                        n_valid[r_empty_idx] = 1'b1;
                                    end
                                end else begin
                                    w_res_status = ST_FULL;
                                end
                            end
                        end
                        OP_UNREGISTER: begin
                            if (!r_found) begin
                                w_res_status = ST_NOT_FOUND;
                            end else if (w_load) begin
                                n_valid[r_hit_idx] = 1'b0;
                            end
                        end
                        OP_WRITE_FIRST: begin
                            if (!r_found) begin
                                w_res_status = ST_NOT_FOUND;
                            end else begin
                                w_mem_wdata.first = r_word;
                                w_mem_we          = w_load;
                            end
                        end
                        OP_WRITE_SECOND: begin
                            if (!r_found) begin
                                w_res_status = ST_NOT_FOUND;
                            end else begin
                                w_mem_wdata.second = r_word;
                                w_mem_we           = w_load;
                            end
                        end
                        OP_READ_FIRST: begin
                            if (!r_found) begin
                                w_res_status = ST_NOT_FOUND;
                            end else begin
                                w_res_word = r_hit_row.first;
                            end
                        end
                        OP_READ_SECOND: begin
                            if (!r_found) begin
                                w_res_status = ST_NOT_FOUND;
                            end else begin
                                w_res_word = r_hit_row.second;
                            end
                        end
                        default: begin
                            w_res_status = ST_OK;
                        end
                    endcase
                end
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_res_status;
                    n_out_word   = w_res_word;
                    n_out_slot   = (!r_trivial && w_res_status == ST_OK) ?
                                   w_slot_ext[SLOT_OUT_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_issue       <= 1'b0;
            r_cmp_vld     <= 1'b0;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
            r_trivial     <= 1'b0;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_issue       <= n_issue;
            r_cmp_vld     <= n_cmp_vld;
            r_found       <= n_found;
            r_empty_found <= n_empty_found;
            r_trivial     <= n_trivial;
            r_valid       <= n_valid;
            r_out_valid   <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_word       <= n_word;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_idx    <= n_hit_idx;
        r_hit_row    <= n_hit_row;
        r_empty_idx  <= n_empty_idx;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_word   <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_row <= r_mem[r_addr];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_word, r_out_slot, r_out_status};

    a_full_only_when_all_used: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res_status == ST_FULL) |-> (&r_valid)
    ) else $error("table full reported with an empty slot left");

    a_register_sets_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_trivial && r_op == OP_REGISTER && w_res_status == ST_OK)
            |=> r_valid[$past(w_act_idx)]
    ) else $error("registered slot not marked valid");

    a_unregister_clears_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_trivial && r_op == OP_UNREGISTER && w_res_status == ST_OK)
            |=> !r_valid[$past(w_act_idx)]
    ) else $error("unregistered slot still valid");

    a_hit_on_valid_slot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT && !r_trivial && r_found) |-> r_valid[r_hit_idx]
    ) else $error("matched slot is not valid");

endmodule
`default_nettype wire
